### rtl/core/lkvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Field widths, register reset value, operation codes and the control word
// that the top level broadcasts to every cell of the recency chain.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic cmp;
    logic hit_move;
    logic insert;
  } lkvc_ctl_t;

endpackage

`default_nettype wire

### rtl/core/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Entries sit in a chain of cells ordered from most to least recent. A key is
// compared in every cell at once; a hit moves its entry to the front, a write
// miss shifts the whole chain and drops what lies beyond the capacity.
//
//   channel   dir  word contents (low bit first)             taken when
//   s_axis    in   tdata: lookup_key, write_value; tuser: kind  tvalid & tready
//   m_axis    out  tdata: read_value; tuser: hit             tvalid & tready
//   cfg       in   cfg_wr_data: capacity_limit               cfg_wr_en
//
// Each word passes a compare state (key compared in all cells) and an update
// state (chain moved, result register loaded); the next word is taken in the
// update state. A result that is not taken holds the chain and input.
// Reset is synchronous: it empties the cache and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MaxEntries = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire  [63:0]                 s_axis_tdata,   // lookup_key, write_value
  input  wire  [0:0]                  s_axis_tuser,   // kind
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // read_value
  output logic [0:0]                  m_axis_tuser,   // hit
  input  wire                         cfg_wr_en,
  input  wire  [lkvc_pkg::CAP_W-1:0]  cfg_wr_data
);
  import lkvc_pkg::*;

  localparam int OccW = $clog2(MaxEntries + 1);
  localparam int CmpW = (OccW > CAP_W) ? OccW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [CAP_W-1:0] capacity_limit;
  logic [OccW-1:0] occupancy;
  logic            op_kind;
  key_t            op_key;
  val_t            op_value;

  logic            accept;
  logic            go;
  logic            hit;
  val_t            hit_value;
  val_t            front_value;
  logic [CmpW-1:0] cap_ext;
  logic [CmpW-1:0] eff_ext;
  logic [OccW-1:0] eff_cap;
  logic [OccW-1:0] new_occ;
  lkvc_ctl_t       ctl;

  key_t            cell_key   [MaxEntries];
  val_t            cell_value [MaxEntries];
  val_t            cell_mval  [MaxEntries];
  logic [MaxEntries-1:0] cell_match;
  logic [MaxEntries:0]   seen;

  assign go            = (state == S_UPD) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (state == S_IDLE) || go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign hit = |cell_match;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit_value = hit_value | cell_mval[i];
    end
  end

  assign front_value = (hit && op_kind == KIND_LOOKUP) ? hit_value : op_value;

  assign cap_ext = CmpW'(capacity_limit);
  always_comb begin
    if (cap_ext == '0) begin
      eff_ext = CmpW'(1);
    end else if (cap_ext > CmpW'(MaxEntries)) begin
      eff_ext = CmpW'(MaxEntries);
    end else begin
      eff_ext = cap_ext;
    end
  end
  assign eff_cap = eff_ext[OccW-1:0];
  assign new_occ = (occupancy >= eff_cap) ? eff_cap : occupancy + OccW'(1);

  assign ctl.cmp      = (state == S_CMP);
  assign ctl.hit_move = go && hit;
  assign ctl.insert   = go && !hit && (op_kind == KIND_WRITE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_CMP;
      S_CMP:  state_next = S_UPD;
      S_UPD: begin
        if (go) state_next = accept ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      capacity_limit <= CAP_RESET;
      occupancy      <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        capacity_limit <= cfg_wr_data;
      end
      if (ctl.insert) begin
        occupancy <= new_occ;
      end
      if (go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind  <= s_axis_tuser[0];
      op_key   <= s_axis_tdata[31:0];
      op_value <= s_axis_tdata[63:32];
    end
    if (go) begin
      m_axis_tuser[0] <= hit;
      m_axis_tdata    <= (hit && op_kind == KIND_LOOKUP) ? hit_value : '0;
    end
  end

  assign seen[MaxEntries] = 1'b0;

  for (genvar gi = 0; gi < MaxEntries; gi++) begin : g_cell
    key_t left_key;
    val_t left_value;
    logic keep;

    if (gi == 0) begin : g_front
      assign left_key   = op_key;
      assign left_value = front_value;
    end else begin : g_chain
      assign left_key   = cell_key[gi-1];
      assign left_value = cell_value[gi-1];
    end

    assign keep = (new_occ > OccW'(gi));

    lkvc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .keep        (keep),
      .op_key      (op_key),
      .left_key    (left_key),
      .left_value  (left_value),
      .seen_in     (seen[gi+1]),
      .seen_out    (seen[gi]),
      .key         (cell_key[gi]),
      .value       (cell_value[gi]),
      .match       (cell_match[gi]),
      .match_value (cell_mval[gi])
    );
  end

endmodule

`default_nettype wire

### rtl/core/lkvc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell: one position of the recency chain
// Holds one entry, compares it against the broadcast key and takes the entry
// of its more recent neighbour when the chain shifts.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  lkvc_pkg::lkvc_ctl_t ctl,
  input  wire                 keep,
  input  lkvc_pkg::key_t      op_key,
  input  lkvc_pkg::key_t      left_key,
  input  lkvc_pkg::val_t      left_value,
  input  wire                 seen_in,
  output logic                seen_out,
  output lkvc_pkg::key_t      key,
  output lkvc_pkg::val_t      value,
  output logic                match,
  output lkvc_pkg::val_t      match_value
);
  import lkvc_pkg::*;

  logic valid;
  logic shift;

  assign seen_out    = seen_in | match;
  assign shift       = ctl.insert | (ctl.hit_move & seen_out);
  assign match_value = match ? value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        match <= valid && (key == op_key);
      end
      if (ctl.insert) begin
        valid <= keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= left_key;
      value <= left_value;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lkvc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module lkvc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser
);

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word valid after reset");

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken in compare cycle");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
    else $error("miss returned non-zero data");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
